// ===== rtl/core/mcrr_pkg.sv =====
// Shared types and constants for the multi-context report reassembler.
// No dependencies.
`default_nettype none
package mcrr_pkg;
  localparam int Contexts = 8;
  localparam int MaxWords = 16;
  localparam int StreamLowBits = 11;
  localparam int SlotBits = $clog2(Contexts);
  localparam int WordIdxBits = $clog2(MaxWords);
  localparam int KeyBits = 34;
  localparam int QDepth = 2;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_WORD     = 3'd1,
    ST_MISSING  = 3'd2,
    ST_BADMOP   = 3'd3,
    ST_NOCTX    = 3'd4,
    ST_MISMATCH = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  // Command handed from front (classify) to back (emit).
  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,  // one status beat
    CMD_ONEWORD = 2'd1, // three words from the command itself
    CMD_DRAIN = 2'd2    // expected words from the slot store
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    status_t status;
    logic [SlotBits-1:0] slot;
    logic [4:0] count;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_EMIT = 2'd1
  } bk_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/mcrr_front.sv =====
// Front part: context table lookup, allocation, word store writes and command issue.
// Depends on mcrr_pkg.
`default_nettype none
module mcrr_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [15:0] task_id,
  input  wire logic [10:0] stream_low,
  input  wire logic [4:0] stream_ext,
  input  wire logic [1:0] package_type,
  input  wire logic sop,
  input  wire logic mop,
  input  wire logic eop,
  input  wire logic [31:0] payload,
  input  wire logic [4:0] expected_words,
  input  wire logic [31:0] aux_task_word,
  input  wire logic [31:0] fault_stream_word,
  output logic cmd_valid,
  output mcrr_pkg::cmd_t cmd,
  input  wire logic cmd_full,
  // back part has popped a drain command
  input  wire logic drain_done,
  // word store write port
  output logic wr_en,
  output logic [mcrr_pkg::SlotBits+mcrr_pkg::WordIdxBits-1:0] wr_addr,
  output logic [31:0] wr_data
);
  logic [mcrr_pkg::Contexts-1:0] ctx_valid;
  logic [mcrr_pkg::KeyBits-1:0] ctx_key [mcrr_pkg::Contexts];
  logic [7:0] ctx_count [mcrr_pkg::Contexts];

  logic [15:0] stream;
  logic [mcrr_pkg::KeyBits-1:0] key;
  logic hit, free_found;
  logic [mcrr_pkg::SlotBits-1:0] hit_slot, free_slot, slot;
  logic have_slot, open_ctx;
  logic [7:0] c;
  logic [7:0] c_new;
  logic accept;
  logic drain_busy;

  // Hold input while a drain is in flight so a reopened slot keeps its words.
  assign in_stall = cmd_full || drain_busy;
  assign accept = in_valid && !in_stall;

  always_comb begin
    logic [26:0] s_wide;
    s_wide = {11'd0, stream_ext, stream_low} | 27'd0;
    s_wide = {22'd0, stream_ext} << mcrr_pkg::StreamLowBits;
    s_wide = s_wide | {16'd0, stream_low};
    stream = s_wide[15:0];
  end
  assign key = {task_id, stream, package_type};

  // Lowest matching valid slot and lowest free slot.
  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    free_found = 1'b0;
    free_slot = '0;
    for (int i = mcrr_pkg::Contexts - 1; i >= 0; i--) begin
      if (ctx_valid[i] && ctx_key[i] == key) begin
        hit = 1'b1;
        hit_slot = i[mcrr_pkg::SlotBits-1:0];
      end
      if (!ctx_valid[i]) begin
        free_found = 1'b1;
        free_slot = i[mcrr_pkg::SlotBits-1:0];
      end
    end
  end

  // Word count before this beat; sop restarts it.
  assign c = sop ? 8'd0 : ctx_count[hit_slot];
  assign c_new = (c == 8'd255) ? c : c + 8'd1;

  // Classify the beat.
  always_comb begin
    cmd = '0;
    cmd.kind = mcrr_pkg::CMD_SINGLE;
    cmd.status = mcrr_pkg::ST_PENDING;
    cmd.w0 = payload;
    cmd.w1 = aux_task_word;
    cmd.w2 = fault_stream_word;
    cmd.count = expected_words;
    open_ctx = 1'b0;
    have_slot = hit;
    slot = hit_slot;
    if (expected_words == 5'd1) begin
      if (sop && eop) cmd.kind = mcrr_pkg::CMD_ONEWORD;
      else cmd.status = mcrr_pkg::ST_MISSING;
      have_slot = 1'b0;
    end else if (sop && mop) begin
      cmd.status = mcrr_pkg::ST_BADMOP;
      have_slot = 1'b0;
    end else if (sop && !hit && !free_found) begin
      cmd.status = mcrr_pkg::ST_FULL;
      have_slot = 1'b0;
    end else begin
      if (sop) begin
        open_ctx = 1'b1;
        have_slot = 1'b1;
        if (!hit) slot = free_slot;
      end
      if (eop) begin
        if (!have_slot) cmd.status = mcrr_pkg::ST_NOCTX;
        else if ((c_new == {3'd0, expected_words}) && expected_words != 5'd0
                 && {27'd0, expected_words} <= mcrr_pkg::MaxWords) begin
          cmd.kind = mcrr_pkg::CMD_DRAIN;
          cmd.status = mcrr_pkg::ST_WORD;
        end else cmd.status = mcrr_pkg::ST_MISMATCH;
      end
    end
    cmd.slot = slot;
  end

  assign cmd_valid = accept;

  // Word store write: only below expected and capacity.
  assign wr_en = accept && have_slot && (c < {3'd0, expected_words})
                 && ({24'd0, c} < mcrr_pkg::MaxWords);
  assign wr_addr = {slot, c[mcrr_pkg::WordIdxBits-1:0]};
  assign wr_data = payload;

  // Context table update; eop frees the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_valid <= '0;
    end else if (accept && have_slot) begin
      if (open_ctx) ctx_key[slot] <= key;
      ctx_valid[slot] <= !eop;
      ctx_count[slot] <= c_new;
    end
  end

  // Drain in flight: set on issue, cleared when the back part pops it.
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_busy <= 1'b0;
    end else if (accept && cmd.kind == mcrr_pkg::CMD_DRAIN) begin
      drain_busy <= 1'b1;
    end else if (drain_done) begin
      drain_busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mcrr_queue.sv =====
// Short command queue between front and back parts.
// Depends on mcrr_pkg.
`default_nettype none
module mcrr_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire mcrr_pkg::cmd_t push_data,
  output logic full,
  output logic not_empty,
  output mcrr_pkg::cmd_t head,
  input  wire logic pop
);
  localparam int PtrBits = $clog2(mcrr_pkg::QDepth);
  mcrr_pkg::cmd_t mem [mcrr_pkg::QDepth];
  logic [PtrBits-1:0] wptr, rptr;
  logic [PtrBits:0] fill;

  assign full = fill == mcrr_pkg::QDepth[PtrBits:0];
  assign not_empty = fill != '0;
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      fill <= fill + {{PtrBits{1'b0}}, push} - {{PtrBits{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end
endmodule
`default_nettype wire

// ===== rtl/core/mcrr_back.sv =====
// Back part: word store and result sequencer with output register.
// Depends on mcrr_pkg.
`default_nettype none
module mcrr_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_avail,
  input  wire mcrr_pkg::cmd_t cmd,
  output logic cmd_pop,
  input  wire logic wr_en,
  input  wire logic [mcrr_pkg::SlotBits+mcrr_pkg::WordIdxBits-1:0] wr_addr,
  input  wire logic [31:0] wr_data,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [2:0] status,
  output logic [31:0] word,
  output logic last
);
  localparam int Depth = mcrr_pkg::Contexts * mcrr_pkg::MaxWords;
  logic [31:0] store [Depth];
  logic [31:0] rd_data;

  mcrr_pkg::bk_state_t state, state_next;
  logic [4:0] idx, idx_next;
  logic rd_pend, rd_pend_next;
  logic load;
  logic [2:0] st_d;
  logic [31:0] w_d;
  logic l_d;
  logic [mcrr_pkg::SlotBits+mcrr_pkg::WordIdxBits-1:0] rd_addr;

  // Output register frees when empty or taken.
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    rd_data <= store[rd_addr];
  end
  assign rd_addr = {cmd.slot, idx[mcrr_pkg::WordIdxBits-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcrr_pkg::BK_IDLE;
      idx <= '0;
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      rd_pend <= rd_pend_next;
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= st_d;
      word <= w_d;
      last <= l_d;
    end
  end

  // Sequencer: for drains, issue one read, then load the registered read word once the output register is free.
  always_comb begin
    state_next = state;
    idx_next = idx;
    rd_pend_next = rd_pend;
    load = 1'b0;
    cmd_pop = 1'b0;
    st_d = cmd.status;
    w_d = 32'd0;
    l_d = 1'b1;
    case (state)
      mcrr_pkg::BK_IDLE: begin
        if (cmd_avail) begin
          state_next = mcrr_pkg::BK_EMIT;
          idx_next = '0;
          rd_pend_next = 1'b0;
        end
      end
      mcrr_pkg::BK_EMIT: begin
        case (cmd.kind)
          mcrr_pkg::CMD_ONEWORD: begin
            st_d = mcrr_pkg::ST_WORD;
            w_d = (idx == 5'd0) ? cmd.w0 : (idx == 5'd1) ? cmd.w1 : cmd.w2;
            l_d = idx == 5'd2;
            if (out_free) begin
              load = 1'b1;
              idx_next = idx + 5'd1;
              if (l_d) begin
                cmd_pop = 1'b1;
                state_next = mcrr_pkg::BK_IDLE;
              end
            end
          end
          mcrr_pkg::CMD_DRAIN: begin
            w_d = rd_data;
            l_d = (idx + 5'd1) == cmd.count;
            if (!rd_pend) rd_pend_next = 1'b1;
            else if (out_free) begin
              load = 1'b1;
              rd_pend_next = 1'b0;
              idx_next = idx + 5'd1;
              if (l_d) begin
                cmd_pop = 1'b1;
                state_next = mcrr_pkg::BK_IDLE;
              end
            end
          end
          default: begin
            if (out_free) begin
              load = 1'b1;
              cmd_pop = 1'b1;
              state_next = mcrr_pkg::BK_IDLE;
            end
          end
        endcase
      end
      default: state_next = mcrr_pkg::BK_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/multi_context_report_reassembler.sv =====
// Top level of the multi-context report reassembler.
// Depends on mcrr_pkg, mcrr_front, mcrr_queue, mcrr_back.
//
// Input channel (in_valid/in_stall) takes one report word per beat, keyed by
// task, stream and package type. The front part looks up or opens a context
// in an eight-slot table, stores the word and pushes a command into a
// two-entry queue. The back part turns each command into result beats on
// the output channel (out_valid/out_stall): one status beat for pending and
// error words, three beats for a one-word package, and the stored words for
// a completed package, last set on the final beat of each input.
// A status beat passes through the command queue and the sequencer's idle and
// emit states into the output register; a drained word also waits for the
// registered word store read. The back sequencer returns to idle between
// commands and takes a new command only after the last beat of the previous one.
// in_stall rises when the command queue is full and while a drain is in
// flight. A stalled output holds its beat and stalls the sequencer. Reset
// (rst, synchronous) frees all contexts and empties the queue; the word
// store is not cleared.
`default_nettype none
module multi_context_report_reassembler (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [15:0] task_id,
  input  wire logic [10:0] stream_low,
  input  wire logic [4:0] stream_ext,
  input  wire logic [1:0] package_type,
  input  wire logic sop,
  input  wire logic mop,
  input  wire logic eop,
  input  wire logic [31:0] payload,
  input  wire logic [4:0] expected_words,
  input  wire logic [31:0] aux_task_word,
  input  wire logic [31:0] fault_stream_word,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [2:0] status,
  output logic [31:0] word,
  output logic last
);
  mcrr_pkg::cmd_t cmd_in, cmd_head;
  logic cmd_push, q_full, q_avail, q_pop, wr_en;
  logic drain_done;
  logic [mcrr_pkg::SlotBits+mcrr_pkg::WordIdxBits-1:0] wr_addr;
  logic [31:0] wr_data;

  assign drain_done = q_pop && (cmd_head.kind == mcrr_pkg::CMD_DRAIN);

  mcrr_front u_front (
    .clk, .rst, .in_valid, .in_stall, .task_id, .stream_low, .stream_ext,
    .package_type, .sop, .mop, .eop, .payload, .expected_words,
    .aux_task_word, .fault_stream_word,
    .cmd_valid(cmd_push), .cmd(cmd_in), .cmd_full(q_full),
    .drain_done,
    .wr_en, .wr_addr, .wr_data
  );

  mcrr_queue u_queue (
    .clk, .rst, .push(cmd_push), .push_data(cmd_in), .full(q_full),
    .not_empty(q_avail), .head(cmd_head), .pop(q_pop)
  );

  mcrr_back u_back (
    .clk, .rst, .cmd_avail(q_avail), .cmd(cmd_head), .cmd_pop(q_pop),
    .wr_en, .wr_addr, .wr_data,
    .out_valid, .out_stall, .status, .word, .last
  );
endmodule
`default_nettype wire
